@@ design/bhs_pkg.sv @@
// ----------------------------------------------------------------------------
// bhs_pkg
// Shared constants, command codes and controller/datapath link types for the
// bucketed hash set.
// ----------------------------------------------------------------------------
`default_nettype none

package bhs_pkg;

  localparam int NUM_BUCKETS = 64;
  localparam int WAYS        = 4;
  localparam int ENTRIES     = NUM_BUCKETS * WAYS;

  localparam int KEY_W  = 31;
  localparam int CMD_W  = 2;
  localparam int MOD_W  = 7;
  localparam int BIT_W  = $clog2(KEY_W);
  localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int BKT_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int ADDR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam logic [MOD_W-1:0] MOD_RESET = MOD_W'(31);

  localparam logic [CMD_W-1:0] CMD_ADD      = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CONTAINS = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE   = 2'd2;

  typedef struct packed {
    logic             load;
    logic             div_step;
    logic [BIT_W-1:0] bit_idx;
    logic             rd;
    logic             cmp;
    logic [WAY_W-1:0] way;
    logic             commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic out_busy;
  } ctl_sts_t;

endpackage

`default_nettype wire

@@ design/bhs_if.sv @@
// ----------------------------------------------------------------------------
// bhs_if
// Valid/ready channels for commands into and results out of the hash set.
// ----------------------------------------------------------------------------
`default_nettype none

interface bhs_in_if;
  logic                    valid;
  logic                    ready;
  logic [bhs_pkg::CMD_W-1:0] cmd;
  logic [bhs_pkg::KEY_W-1:0] key;

  modport source (output valid, output cmd, output key, input ready);
  modport sink   (input valid, input cmd, input key, output ready);
endinterface

interface bhs_out_if;
  logic valid;
  logic ready;
  logic found;
  logic status;

  modport source (output valid, output found, output status, input ready);
  modport sink   (input valid, input found, input status, output ready);
endinterface

`default_nettype wire

@@ design/bhs_dpath.sv @@
// ----------------------------------------------------------------------------
// bhs_dpath
// Datapath: modulus register, bit-serial remainder, slot key memory, slot
// valid bits, bucket walk results and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bhs_dpath (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic [bhs_pkg::MOD_W-1:0] cfg_wdata,
  input  wire logic [bhs_pkg::CMD_W-1:0] in_cmd,
  input  wire logic [bhs_pkg::KEY_W-1:0] in_key,
  input  wire bhs_pkg::ctl_cmd_t         ctl,
  output bhs_pkg::ctl_sts_t              sts,
  input  wire logic                      out_ready,
  output logic                           out_valid,
  output logic                           out_found,
  output logic                           out_status
);
  import bhs_pkg::*;

  logic [MOD_W-1:0]  mod_r;
  logic [MOD_W-1:0]  div_r;
  logic [MOD_W-1:0]  rem_r;
  logic [MOD_W-1:0]  active;
  logic [MOD_W:0]    rem_sh;
  logic [MOD_W:0]    rem_sub;
  logic [CMD_W-1:0]  cmd_r;
  logic [KEY_W-1:0]  key_r;
  logic [BKT_W-1:0]  bucket;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] addr_r;
  logic [KEY_W-1:0]  rdata_r;
  logic [KEY_W-1:0]  mem [ENTRIES];
  logic [ENTRIES-1:0] valid_r;
  logic              hit_r;
  logic              free_r;
  logic [ADDR_W-1:0] hit_addr_r;
  logic [ADDR_W-1:0] free_addr_r;
  logic              out_valid_r;
  logic              found_r;
  logic              status_r;
  logic              slot_v;
  logic              slot_match;

  // bucket count in use, clamped to 1..NUM_BUCKETS
  always_comb begin
    if (mod_r == '0) begin
      active = MOD_W'(1);
    end else if (int'(mod_r) > NUM_BUCKETS) begin
      active = MOD_W'(NUM_BUCKETS);
    end else begin
      active = mod_r;
    end
  end

  assign rem_sh  = {rem_r, key_r[ctl.bit_idx]};
  assign rem_sub = rem_sh - {1'b0, div_r};
  assign bucket  = BKT_W'(rem_r);
  assign rd_addr = ADDR_W'(int'(bucket) * WAYS + int'(ctl.way));
  assign slot_v     = valid_r[addr_r];
  assign slot_match = slot_v && (rdata_r == key_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= MOD_RESET;
    end else if (cfg_we) begin
      mod_r <= cfg_wdata;
    end
  end

  // remainder, one key bit per cycle, msb first
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r <= in_cmd;
      key_r <= in_key;
      div_r <= active;
      rem_r <= '0;
    end else if (ctl.div_step) begin
      if (rem_sh >= {1'b0, div_r}) begin
        rem_r <= MOD_W'(rem_sub);
      end else begin
        rem_r <= MOD_W'(rem_sh);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      rdata_r <= mem[rd_addr];
      addr_r  <= rd_addr;
    end
    if (ctl.commit && cmd_r == CMD_ADD && free_r) begin
      mem[free_addr_r] <= key_r;
    end
  end

  // lowest matching and lowest free slot of the bucket
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r  <= 1'b0;
      free_r <= 1'b0;
    end else if (ctl.load) begin
      hit_r  <= 1'b0;
      free_r <= 1'b0;
    end else if (ctl.cmp) begin
      if (slot_match && !hit_r) begin
        hit_r      <= 1'b1;
        hit_addr_r <= addr_r;
      end
      if (!slot_v && !free_r) begin
        free_r      <= 1'b1;
        free_addr_r <= addr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ctl.commit) begin
      case (cmd_r)
        CMD_ADD: begin
          if (free_r) begin
            valid_r[free_addr_r] <= 1'b1;
          end
        end
        CMD_REMOVE: begin
          if (hit_r) begin
            valid_r[hit_addr_r] <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      status_r    <= 1'b0;
    end else if (ctl.commit) begin
      out_valid_r <= 1'b1;
      case (cmd_r)
        CMD_ADD: begin
          found_r  <= 1'b0;
          status_r <= !free_r;
        end
        CMD_CONTAINS, CMD_REMOVE: begin
          found_r  <= hit_r;
          status_r <= 1'b0;
        end
        default: begin
          found_r  <= 1'b0;
          status_r <= 1'b0;
        end
      endcase
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.out_busy = out_valid_r && !out_ready;
  assign out_valid    = out_valid_r;
  assign out_found    = found_r;
  assign out_status   = status_r;

`ifndef NO_ASSERTIONS
  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.commit |=> out_valid_r)
    else $error("result not presented after commit");

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(found_r && status_r))
    else $error("found and full flagged together");

  a_add_sets: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.commit && cmd_r == CMD_ADD && free_r) |=> valid_r[$past(free_addr_r)])
    else $error("add did not mark slot valid");

  a_rm_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.commit && cmd_r == CMD_REMOVE && hit_r) |=> !valid_r[$past(hit_addr_r)])
    else $error("remove did not clear slot");
`endif

endmodule

`default_nettype wire

@@ design/bhs_ctrl.sv @@
// ----------------------------------------------------------------------------
// bhs_ctrl
// Sequencer: accept, remainder steps, bucket walk and commit.
// ----------------------------------------------------------------------------
`default_nettype none

module bhs_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire bhs_pkg::ctl_sts_t sts,
  output bhs_pkg::ctl_cmd_t     ctl
);
  import bhs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_RD,
    S_CMP,
    S_FIN
  } state_t;

  state_t           state_r;
  logic [BIT_W-1:0] bit_r;
  logic [WAY_W-1:0] way_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      bit_r   <= '0;
      way_r   <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_DIV;
            bit_r   <= BIT_W'(KEY_W - 1);
          end
        end
        S_DIV: begin
          if (bit_r == '0) begin
            state_r <= S_RD;
            way_r   <= '0;
          end else begin
            bit_r <= bit_r - BIT_W'(1);
          end
        end
        S_RD: begin
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (way_r == WAY_W'(WAYS - 1)) begin
            state_r <= S_FIN;
          end else begin
            way_r   <= way_r + WAY_W'(1);
            state_r <= S_RD;
          end
        end
        S_FIN: begin
          if (!sts.out_busy) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    ctl          = '0;
    ctl.bit_idx  = bit_r;
    ctl.way      = way_r;
    ctl.load     = in_ready && in_valid;
    ctl.div_step = (state_r == S_DIV);
    ctl.rd       = (state_r == S_RD);
    ctl.cmp      = (state_r == S_CMP);
    ctl.commit   = (state_r == S_FIN) && !sts.out_busy;
  end

endmodule

`default_nettype wire

@@ design/bucketed_hash_set.sv @@
// latency: 1 + 31 + 2*WAYS + 1 cycles from input transfer to result (41 at WAYS = 4)
// throughput: one item per 41 cycles, set by the bit-serial remainder loop
//   and the walk of one memory read and one compare per slot
// a new item may be taken while the previous result waits in the output register
// reset: synchronous active-low rst_n clears all slot valid bits at once,
//   modulus returns to 31; no clearing pass
// ----------------------------------------------------------------------------
// bucketed_hash_set
// Hash set of 31-bit keys in fixed buckets of WAYS slots; add, contains and
// remove, bucket chosen as key modulo a configured bucket count.
// ----------------------------------------------------------------------------
`default_nettype none

module bucketed_hash_set (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic [bhs_pkg::MOD_W-1:0] cfg_wdata,
  bhs_in_if.sink                         in_ch,
  bhs_out_if.source                      out_ch
);
  import bhs_pkg::*;

  ctl_cmd_t ctl;
  ctl_sts_t sts;

  bhs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  bhs_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_cmd     (in_ch.cmd),
    .in_key     (in_ch.key),
    .ctl        (ctl),
    .sts        (sts),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_found  (out_ch.found),
    .out_status (out_ch.status)
  );

endmodule

`default_nettype wire
